FILE: hw/rtl/bounded_event_fifo_with_pair_push_unit_assert.svh
// ----------------------------------------------------------------------------
// Event FIFO assertion macros
// Shorthand for clocked, reset-qualified assertions in the event FIFO checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_EVENT_FIFO_WITH_PAIR_PUSH_UNIT_ASSERT_SVH
`define BOUNDED_EVENT_FIFO_WITH_PAIR_PUSH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bef_pkg.sv
// ----------------------------------------------------------------------------
// Event FIFO package
// Sizes, codes, shared types and pointer helpers for the event FIFO.
// ----------------------------------------------------------------------------
package bef_pkg;

  // Storage geometry
  localparam int QueueDepth = 256;
  localparam int EventBytes = 8;
  localparam int EventW     = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int PosW       = $clog2(2 * QueueDepth);
  localparam int OccW       = 9;
  localparam int CountW     = 32;
  localparam int OpW        = 2;
  localparam int StatusW    = 2;

  // Bits of a payload that the store keeps
  localparam logic [EventW-1:0] EventMask =
    EventW'({EventW{1'b1}} >> (EventW - 8 * EventBytes));

  typedef logic [PosW-1:0] pos_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH1 = 2'd0,
    OP_PUSH2 = 2'd1,
    OP_POP   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PAIR,
    FSM_POP
  } fsm_e;

  // Store access from the control unit
  typedef struct packed {
    logic              we;
    idx_t              waddr;
    logic [EventW-1:0] wdata;
    logic              re;
    idx_t              raddr;
  } mem_req_t;

  // One result beat
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [EventW-1:0] popped_event;
    logic [OccW-1:0]   occupancy;
    logic [CountW-1:0] pushed_count;
    logic [CountW-1:0] popped_count;
    logic [CountW-1:0] dropped_count;
  } result_t;

  // Advance a position, wrapping at twice the depth
  function automatic pos_t pos_next(pos_t p);
    return (p == pos_t'(2 * QueueDepth - 1)) ? '0 : p + pos_t'(1);
  endfunction

  // Fold a position onto a store index
  function automatic idx_t pos_index(pos_t p);
    return (p >= pos_t'(QueueDepth)) ? idx_t'(p - pos_t'(QueueDepth)) : idx_t'(p);
  endfunction

  // Events held between read and write positions
  function automatic pos_t held(pos_t w, pos_t r);
    logic [PosW:0] wrapped;
    wrapped = {1'b0, w} + (PosW + 1)'(2 * QueueDepth) - {1'b0, r};
    return (w >= r) ? w - r : pos_t'(wrapped);
  endfunction

endpackage

FILE: hw/rtl/bounded_event_fifo_with_pair_push_unit.sv
// ----------------------------------------------------------------------------
// Bounded event FIFO with pair push
// Ring FIFO of event words with single push, all-or-nothing pair push and pop.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op_i and the event ports with start_i high; the item is taken at a
//   clock edge where busy_o is low. Every item yields one result beat: done_o
//   is high for exactly one cycle with status, popped event, occupancy and
//   the running pushed, popped and dropped totals.
//   Single push, refused push, pop on empty and the unused code give their
//   beat in the cycle after the start edge; busy_o stays low, so such items
//   may follow every cycle. A stored pair push and a pop pass through the
//   PAIR or POP state and hold busy_o high for one cycle: the store has one
//   write port, so the pair goes in one event per cycle, and a pop waits for
//   the registered read port of the store.
//   A result beat is never held back; the next item is taken while it shows.
//   Reset clears the pointers, totals and result strobe at once. Store
//   contents stay undefined and are not cleared; no entry is read before it
//   was written.
// ----------------------------------------------------------------------------
module bounded_event_fifo_with_pair_push_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [bef_pkg::OpW-1:0]           op_i,
  input  logic [bef_pkg::EventW-1:0]        first_event_i,
  input  logic [bef_pkg::EventW-1:0]        second_event_i,
  output logic                              done_o,
  output logic [bef_pkg::StatusW-1:0]       status_o,
  output logic [bef_pkg::EventW-1:0]        popped_event_o,
  output logic [bef_pkg::OccW-1:0]          occupancy_o,
  output logic [bef_pkg::CountW-1:0]        pushed_count_o,
  output logic [bef_pkg::CountW-1:0]        popped_count_o,
  output logic [bef_pkg::CountW-1:0]        dropped_count_o
);

  bef_pkg::mem_req_t          mem_req;
  logic [bef_pkg::EventW-1:0] mem_rdata;
  bef_pkg::result_t           res;

  bef_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .first_event_i  (first_event_i),
    .second_event_i (second_event_i),
    .busy_o         (busy_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .res_o          (res)
  );

  bef_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Split the result beat onto its ports
  assign done_o          = res.valid;
  assign status_o        = res.status;
  assign popped_event_o  = res.popped_event;
  assign occupancy_o     = res.occupancy;
  assign pushed_count_o  = res.pushed_count;
  assign popped_count_o  = res.popped_count;
  assign dropped_count_o = res.dropped_count;

endmodule

FILE: hw/rtl/bef_store.sv
// ----------------------------------------------------------------------------
// Event FIFO store
// Event word memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bef_store (
  input  logic                           clk_i,
  input  bef_pkg::mem_req_t              req_i,
  output logic [bef_pkg::EventW-1:0]     rdata_o
);

  logic [bef_pkg::EventW-1:0] mem_q [bef_pkg::QueueDepth];
  logic [bef_pkg::EventW-1:0] rdata_q;

  // Write one event word
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bef_ctrl.sv
// ----------------------------------------------------------------------------
// Event FIFO control
// Sequences pushes and pops against the store, keeps pointers and totals,
// and registers one result beat per item.
// ----------------------------------------------------------------------------
module bef_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bef_pkg::OpW-1:0]        op_i,
  input  logic [bef_pkg::EventW-1:0]     first_event_i,
  input  logic [bef_pkg::EventW-1:0]     second_event_i,
  output logic                           busy_o,
  output bef_pkg::mem_req_t              mem_req_o,
  input  logic [bef_pkg::EventW-1:0]     mem_rdata_i,
  output bef_pkg::result_t               res_o
);

  bef_pkg::fsm_e                    state_q, state_d;
  bef_pkg::pos_t                    wp_q, wp_d;
  bef_pkg::pos_t                    rp_q, rp_d;
  logic [bef_pkg::CountW-1:0]       pushed_q, pushed_d;
  logic [bef_pkg::CountW-1:0]       popped_q, popped_d;
  logic [bef_pkg::CountW-1:0]       dropped_q, dropped_d;
  logic [bef_pkg::EventW-1:0]       pair_q, pair_d;
  logic                             res_valid_q, res_valid_d;
  bef_pkg::status_e                 res_status_q, res_status_d;
  logic [bef_pkg::EventW-1:0]       res_pop_q, res_pop_d;
  logic [bef_pkg::OccW-1:0]         res_occ_q, res_occ_d;
  bef_pkg::pos_t                    held_now;
  logic                             fits_one;
  logic                             fits_two;
  logic                             is_empty;

  assign held_now = bef_pkg::held(wp_q, rp_q);
  assign fits_one = held_now < bef_pkg::pos_t'(bef_pkg::QueueDepth);
  assign fits_two = held_now <= bef_pkg::pos_t'(bef_pkg::QueueDepth - 2);
  assign is_empty = (held_now == '0);

  // Next state: a stored pair push and a pop on a non-empty store pass through PAIR or POP
  always_comb begin
    state_d = state_q;
    case (state_q)
      bef_pkg::FSM_IDLE: begin
        if (start_i) begin
          case (bef_pkg::op_e'(op_i))
            bef_pkg::OP_PUSH2: begin
              if (fits_two) state_d = bef_pkg::FSM_PAIR;
            end
            bef_pkg::OP_POP: begin
              if (!is_empty) state_d = bef_pkg::FSM_POP;
            end
            default: begin
              state_d = bef_pkg::FSM_IDLE;
            end
          endcase
        end
      end
      bef_pkg::FSM_PAIR: state_d = bef_pkg::FSM_IDLE;
      bef_pkg::FSM_POP:  state_d = bef_pkg::FSM_IDLE;
      default:           state_d = bef_pkg::FSM_IDLE;
    endcase
  end

  // Outputs and datapath: store access, pointer and total updates, result load
  always_comb begin
    wp_d            = wp_q;
    rp_d            = rp_q;
    pushed_d        = pushed_q;
    popped_d        = popped_q;
    dropped_d       = dropped_q;
    pair_d          = pair_q;
    res_valid_d     = 1'b0;
    res_status_d    = bef_pkg::ST_DONE;
    res_pop_d       = '0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = bef_pkg::pos_index(wp_q);
    mem_req_o.wdata = first_event_i & bef_pkg::EventMask;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = bef_pkg::pos_index(rp_q);
    case (state_q)
      bef_pkg::FSM_IDLE: begin
        if (start_i) begin
          case (bef_pkg::op_e'(op_i))
            bef_pkg::OP_PUSH1: begin
              res_valid_d = 1'b1;
              if (fits_one) begin
                mem_req_o.we = 1'b1;
                wp_d         = bef_pkg::pos_next(wp_q);
                pushed_d     = pushed_q + bef_pkg::CountW'(1);
              end else begin
                res_status_d = bef_pkg::ST_FULL;
                dropped_d    = dropped_q + bef_pkg::CountW'(1);
              end
            end
            bef_pkg::OP_PUSH2: begin
              if (fits_two) begin
                // Write the first beat now, hold the second for next cycle
                mem_req_o.we = 1'b1;
                wp_d         = bef_pkg::pos_next(wp_q);
                pair_d       = second_event_i & bef_pkg::EventMask;
              end else begin
                res_valid_d  = 1'b1;
                res_status_d = bef_pkg::ST_FULL;
                dropped_d    = dropped_q + bef_pkg::CountW'(2);
              end
            end
            bef_pkg::OP_POP: begin
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = bef_pkg::ST_EMPTY;
              end else begin
                mem_req_o.re = 1'b1;
              end
            end
            default: begin
              // Unused code: report done, change nothing
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      bef_pkg::FSM_PAIR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = pair_q;
        wp_d            = bef_pkg::pos_next(wp_q);
        pushed_d        = pushed_q + bef_pkg::CountW'(2);
        res_valid_d     = 1'b1;
      end
      bef_pkg::FSM_POP: begin
        rp_d        = bef_pkg::pos_next(rp_q);
        popped_d    = popped_q + bef_pkg::CountW'(1);
        res_pop_d   = mem_rdata_i & bef_pkg::EventMask;
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
    res_occ_d = bef_pkg::OccW'(bef_pkg::held(wp_d, rp_d));
  end

  // Control state, pointers and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bef_pkg::FSM_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      pushed_q    <= '0;
      popped_q    <= '0;
      dropped_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      pushed_q    <= pushed_d;
      popped_q    <= popped_d;
      dropped_q   <= dropped_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload: held second event and result fields
  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_pop_q    <= res_pop_d;
      res_occ_q    <= res_occ_d;
    end
  end

  assign busy_o              = (state_q != bef_pkg::FSM_IDLE);
  assign res_o.valid         = res_valid_q;
  assign res_o.status        = res_status_q;
  assign res_o.popped_event  = res_pop_q;
  assign res_o.occupancy     = res_occ_q;
  assign res_o.pushed_count  = pushed_q;
  assign res_o.popped_count  = popped_q;
  assign res_o.dropped_count = dropped_q;

endmodule

FILE: hw/rtl/bef_checker.sv
// ----------------------------------------------------------------------------
// Event FIFO checker
// Port-level assertions on the event FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_event_fifo_with_pair_push_unit_assert.svh"

module bef_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic [bef_pkg::OpW-1:0]           op_i,
  input logic [bef_pkg::EventW-1:0]        first_event_i,
  input logic [bef_pkg::EventW-1:0]        second_event_i,
  input logic                              done_o,
  input logic [bef_pkg::StatusW-1:0]       status_o,
  input logic [bef_pkg::EventW-1:0]        popped_event_o,
  input logic [bef_pkg::OccW-1:0]          occupancy_o,
  input logic [bef_pkg::CountW-1:0]        pushed_count_o,
  input logic [bef_pkg::CountW-1:0]        popped_count_o,
  input logic [bef_pkg::CountW-1:0]        dropped_count_o
);

  // A beat only follows an accepted item or a cycle of work
  `BEF_ASSERT_NEXT(a_beat_has_item, !(start_i && !busy_o) && !busy_o, !done_o, "result beat without an item")

  // Occupancy never exceeds the depth
  `BEF_ASSERT_NOW(a_occ_bound, done_o, occupancy_o <= bef_pkg::OccW'(bef_pkg::QueueDepth), "occupancy above depth")

  // An empty pop leaves nothing held and returns a zero event
  `BEF_ASSERT_NOW(a_empty_pop, done_o && status_o == bef_pkg::ST_EMPTY, occupancy_o == '0 && popped_event_o == '0, "empty pop with data")

  // A refused push only happens with at most one free slot
  `BEF_ASSERT_NOW(a_full_drop, done_o && status_o == bef_pkg::ST_FULL, occupancy_o >= bef_pkg::OccW'(bef_pkg::QueueDepth - 1), "push refused with room")

endmodule

bind bounded_event_fifo_with_pair_push_unit bef_checker u_bef_checker (.*);
